### design/conv3x3_image_filter_assert.svh
// ----------------------------------------------------------------------------
// conv3x3 image filter assertion macros
// shared concurrent assertion forms used by the filter rtl
// ----------------------------------------------------------------------------
`ifndef CONV3X3_IMAGE_FILTER_ASSERT_SVH
`define CONV3X3_IMAGE_FILTER_ASSERT_SVH

// condition holds at every clock edge outside reset
`define CVF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CVF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/cvf_pkg.sv
// ----------------------------------------------------------------------------
// cvf_pkg
// shared types, codes and constants of the 3x3 image filter
// ----------------------------------------------------------------------------
package cvf_pkg;

   localparam int PIXEL_W        = 8;
   localparam int CFG_DIM_W      = 11;
   localparam int KERNEL_W       = 3;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 11;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam logic [CFG_DIM_W-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [CFG_DIM_W-1:0] RESET_HEIGHT = 11'd480;

   // filter arithmetic
   localparam int TAP_W        = 4;
   localparam int SUM_W        = 13;
   localparam int KERNEL_COUNT = 5;
   localparam int PROD_W       = 25;
   localparam int MEAN_SHIFT   = 16;
   localparam logic [PROD_W-1:0]        MEAN_RECIP = 25'd7282;
   localparam logic signed [SUM_W-1:0]  SOBEL_BIAS = 13'sd1020;
   localparam int GAUSS_SHIFT  = 4;
   localparam int SOBEL_SHIFT  = 3;

   // output queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   typedef enum logic [KERNEL_W-1:0] {
      KERNEL_IDENTITY = 3'd0,
      KERNEL_MEAN     = 3'd1,
      KERNEL_GAUSS    = 3'd2,
      KERNEL_SOBEL_H  = 3'd3,
      KERNEL_SOBEL_V  = 3'd4
   } kernel_type;

   typedef enum logic {
      BORDER_REPLICATE = 1'b0,
      BORDER_ZERO      = 1'b1
   } border_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KERNEL = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2,
      CSR_BORDER = 2'd3
   } csr_index_type;

   localparam logic signed [TAP_W-1:0] KERNEL_TAPS [KERNEL_COUNT][3][3] = '{
      '{'{4'sd0, 4'sd0, 4'sd0}, '{4'sd0, 4'sd1, 4'sd0}, '{4'sd0, 4'sd0, 4'sd0}},
      '{'{4'sd1, 4'sd1, 4'sd1}, '{4'sd1, 4'sd1, 4'sd1}, '{4'sd1, 4'sd1, 4'sd1}},
      '{'{4'sd1, 4'sd2, 4'sd1}, '{4'sd2, 4'sd4, 4'sd2}, '{4'sd1, 4'sd2, 4'sd1}},
      '{'{-4'sd1, 4'sd0, 4'sd1}, '{-4'sd2, 4'sd0, 4'sd2}, '{-4'sd1, 4'sd0, 4'sd1}},
      '{'{4'sd1, 4'sd2, 4'sd1}, '{4'sd0, 4'sd0, 4'sd0}, '{-4'sd1, -4'sd2, -4'sd1}}
   };

   // 3x3 neighborhood, [row][column], column 2 newest
   typedef logic [2:0][2:0][PIXEL_W-1:0] window_type;

   // one line store entry: pixel two rows up and one row up
   typedef struct packed {
      logic [PIXEL_W-1:0] upper;
      logic [PIXEL_W-1:0] lower;
   } line_pair_type;

   // position flags of the output pixel carried down the pipe
   typedef struct packed {
      logic top_edge;
      logic bottom_edge;
      logic left_edge;
      logic right_edge;
      logic end_of_frame;
   } meta_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               end_of_line;
      logic               end_of_frame;
   } rsp_type;

endpackage

### design/cvf_req_if.sv
// ----------------------------------------------------------------------------
// cvf_req_if
// pixel request channel: valid, ready, pixel and flush flag
// ----------------------------------------------------------------------------
interface cvf_req_if import cvf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_in;
   logic               flush;

   modport source (output valid, pixel_in, flush, input ready);
   modport sink   (input valid, pixel_in, flush, output ready);
endinterface

### design/cvf_rsp_if.sv
// ----------------------------------------------------------------------------
// cvf_rsp_if
// filtered pixel channel: valid, ready, pixel and line/frame markers
// ----------------------------------------------------------------------------
interface cvf_rsp_if import cvf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_out;
   logic               end_of_line;
   logic               end_of_frame;

   modport source (output valid, pixel_out, end_of_line, end_of_frame, input ready);
   modport sink   (input valid, pixel_out, end_of_line, end_of_frame, output ready);
endinterface

### design/cvf_csr_if.sv
// ----------------------------------------------------------------------------
// cvf_csr_if
// register write channel: valid, ready, register index and data
// ----------------------------------------------------------------------------
interface cvf_csr_if import cvf_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### design/cvf_line_win.sv
// ----------------------------------------------------------------------------
// cvf_line_win
// line store memory with read-modify-write per column and the 3x3 window
// ----------------------------------------------------------------------------
module cvf_line_win import cvf_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  logic                        push_emit,
   input  logic [PIXEL_W-1:0]          push_pix,
   input  logic [$clog2(MAX_WIDTH)-1:0] push_col,
   input  meta_type                    push_meta,
   output logic                        s1_emit,
   output logic                        win_valid,
   output meta_type                    win_meta,
   output window_type                  window
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);

   line_pair_type line_mem [MAX_WIDTH];

   logic               s1_valid_ff;
   logic               s1_emit_ff;
   logic [PIXEL_W-1:0] s1_pix_ff;
   logic [ADDR_W-1:0]  s1_col_ff;
   meta_type           s1_meta_ff;
   line_pair_type      rd_ff;
   logic               fwd_ff;
   line_pair_type      fwd_data_ff;
   window_type         win_ff, win_in;
   logic               win_valid_ff;
   meta_type           win_meta_ff;

   line_pair_type entry;
   line_pair_type wr_data;

   // same column written back while being read again
   assign entry   = fwd_ff ? fwd_data_ff : rd_ff;
   assign wr_data = '{upper: entry.lower, lower: s1_pix_ff};

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= wr_data;
      end
      if (push_valid) begin
         rd_ff <= line_mem[push_col];
      end
   end

   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = entry.upper;
         win_in[1][2] = entry.lower;
         win_in[2][2] = s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_emit_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         win_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else begin
         s1_valid_ff  <= push_valid;
         s1_emit_ff   <= push_emit;
         fwd_ff       <= push_valid && s1_valid_ff && (push_col == s1_col_ff);
         win_valid_ff <= s1_valid_ff && s1_emit_ff;
         win_ff       <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff   <= push_pix;
      s1_col_ff   <= push_col;
      s1_meta_ff  <= push_meta;
      fwd_data_ff <= wr_data;
      win_meta_ff <= s1_meta_ff;
   end

   assign s1_emit   = s1_valid_ff && s1_emit_ff;
   assign win_valid = win_valid_ff;
   assign win_meta  = win_meta_ff;
   assign window    = win_ff;

endmodule

### design/cvf_filter.sv
// ----------------------------------------------------------------------------
// cvf_filter
// weighted 3x3 sum with border handling, then kernel scaling
// ----------------------------------------------------------------------------
module cvf_filter import cvf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                win_valid,
   input  meta_type            win_meta,
   input  window_type          window,
   input  logic [KERNEL_W-1:0] kernel_select,
   input  border_type          border_mode,
   output logic                res_valid,
   output rsp_type             res_data
);

   kernel_type              ks;
   logic [1:0]              row_src [3];
   logic [1:0]              col_src [3];
   logic                    row_out [3];
   logic                    col_out [3];
   logic [PIXEL_W-1:0]      tap_pix [3][3];
   logic signed [SUM_W-1:0] term [3][3];
   logic signed [SUM_W-1:0] acc;

   logic                    sum_valid_ff;
   logic signed [SUM_W-1:0] sum_ff;
   kernel_type              kern_ff;
   logic                    eol_ff;
   logic                    eof_ff;

   logic [PROD_W-1:0]       prod;
   logic signed [SUM_W-1:0] biased;
   logic [PIXEL_W-1:0]      pix;

   // codes past vertical sobel act as identity
   assign ks = (kernel_select > KERNEL_SOBEL_V) ? KERNEL_IDENTITY : kernel_type'(kernel_select);

   // outside rows/columns fold onto the center
   always_comb begin
      row_out[0] = win_meta.top_edge;
      row_out[1] = 1'b0;
      row_out[2] = win_meta.bottom_edge;
      col_out[0] = win_meta.left_edge;
      col_out[1] = 1'b0;
      col_out[2] = win_meta.right_edge;
      for (int k = 0; k < 3; k++) begin
         row_src[k] = row_out[k] ? 2'd1 : 2'(k);
         col_src[k] = col_out[k] ? 2'd1 : 2'(k);
      end
   end

   always_comb begin
      acc = '0;
      for (int dy = 0; dy < 3; dy++) begin
         for (int dx = 0; dx < 3; dx++) begin
            if ((row_out[dy] || col_out[dx]) && border_mode == BORDER_ZERO) begin
               tap_pix[dy][dx] = '0;
            end else begin
               tap_pix[dy][dx] = window[row_src[dy]][col_src[dx]];
            end
            term[dy][dx] = SUM_W'(KERNEL_TAPS[ks][dy][dx]) * $signed(SUM_W'(tap_pix[dy][dx]));
            acc = acc + term[dy][dx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= win_valid;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= acc;
      kern_ff <= ks;
      eol_ff  <= win_meta.right_edge;
      eof_ff  <= win_meta.end_of_frame;
   end

   // divide by nine through the reciprocal, exact for sums below 32768
   assign prod   = PROD_W'(sum_ff[SUM_W-2:0]) * MEAN_RECIP;
   assign biased = sum_ff + SOBEL_BIAS;

   always_comb begin
      case (kern_ff) inside
         KERNEL_MEAN:                    pix = prod[MEAN_SHIFT +: PIXEL_W];
         KERNEL_GAUSS:                   pix = sum_ff[GAUSS_SHIFT +: PIXEL_W];
         KERNEL_SOBEL_H, KERNEL_SOBEL_V: pix = biased[SOBEL_SHIFT +: PIXEL_W];
         default:                        pix = sum_ff[PIXEL_W-1:0];
      endcase
   end

   assign res_valid = sum_valid_ff;
   assign res_data  = '{pixel_out: pix, end_of_line: eol_ff, end_of_frame: eof_ff};

endmodule

### design/cvf_out_fifo.sv
// ----------------------------------------------------------------------------
// cvf_out_fifo
// small result queue between the filter pipe and the response channel
// ----------------------------------------------------------------------------
module cvf_out_fifo import cvf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rsp_type               push_data,
   input  logic                  pop,
   output logic                  out_valid,
   output rsp_type               out_data,
   output logic [FIFO_CNT_W-1:0] count
);

   rsp_type                 fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = fifo_mem[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### design/conv3x3_image_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_image_filter: streaming 3x3 convolution over 8-bit grey pixels
// path: request -> line store stage -> window register -> sum register -> result queue
// throughput: one request per cycle while the result queue has room; the line store is a
//   single-port-read memory whose column is read at acceptance and written back the next cycle
// reset: counters, window and queue clear at once; the line store is not cleared
// ----------------------------------------------------------------------------
`include "conv3x3_image_filter_assert.svh"

module conv3x3_image_filter import cvf_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   cvf_req_if.sink    req_ch,
   cvf_rsp_if.source  rsp_ch,
   cvf_csr_if.sink    csr_ch
);

   // column counters index the line store; row counter reaches height+1 while draining
   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
   localparam int WCMP_W = (WDIM_W > CFG_DIM_W) ? WDIM_W : CFG_DIM_W;
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
   localparam int DROW_W = $clog2(MAX_HEIGHT);
   localparam int HCMP_W = (ROW_W > CFG_DIM_W) ? ROW_W : CFG_DIM_W;
   localparam int RES_W  = FIFO_CNT_W + 1;

   // ---------------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------------
   logic [KERNEL_W-1:0]  kernel_ff;
   logic [CFG_DIM_W-1:0] width_ff;
   logic [CFG_DIM_W-1:0] height_ff;
   border_type           border_ff;
   logic                 csr_wr;
   logic                 csr_restart;

   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid && csr_ch.ready;

   // any geometry write starts a new frame
   assign csr_restart = csr_wr && (csr_index_type'(csr_ch.index) == CSR_WIDTH ||
                                   csr_index_type'(csr_ch.index) == CSR_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= KERNEL_IDENTITY;
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         border_ff <= BORDER_REPLICATE;
      end else if (csr_wr) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_KERNEL: kernel_ff <= csr_ch.data[KERNEL_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_ch.data[CFG_DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_ch.data[CFG_DIM_W-1:0];
            CSR_BORDER: border_ff <= border_type'(csr_ch.data[0]);
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // effective geometry: zero reads as one, oversize clamps to the maximum
   // ---------------------------------------------------------------------------
   logic [WCMP_W-1:0] w_ext, w_eff;
   logic [HCMP_W-1:0] h_ext, h_eff;

   always_comb begin
      w_ext = WCMP_W'(width_ff);
      h_ext = HCMP_W'(height_ff);
      if (w_ext == '0) begin
         w_eff = WCMP_W'(1);
      end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
         w_eff = WCMP_W'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      if (h_ext == '0) begin
         h_eff = HCMP_W'(1);
      end else if (h_ext > HCMP_W'(MAX_HEIGHT)) begin
         h_eff = HCMP_W'(MAX_HEIGHT);
      end else begin
         h_eff = h_ext;
      end
   end

   // ---------------------------------------------------------------------------
   // request stage: raster position of the arriving pixel and of the output pixel
   // ---------------------------------------------------------------------------
   logic [ADDR_W-1:0] src_col_ff, src_col_in;
   logic [ROW_W-1:0]  src_row_ff, src_row_in;
   logic [ADDR_W-1:0] dst_col_ff, dst_col_in;
   logic [DROW_W-1:0] dst_row_ff, dst_row_in;

   logic               credit_ok;
   logic               accept;
   logic               draining;
   logic               active;
   logic               emit;
   logic [PIXEL_W-1:0] push_pix;
   meta_type           meta;
   logic               col_wrap;

   assign req_ch.ready = credit_ok;
   assign accept       = req_ch.valid && credit_ok;

   // once every pixel of the frame is in, each request drains one output (in a one-row frame, all but the first)
   assign draining = HCMP_W'(src_row_ff) >= h_eff;
   // a flush while pixels are still expected is dropped without effect
   assign active   = accept && (draining || !req_ch.flush);
   assign push_pix = draining ? '0 : req_ch.pixel_in;

   // output starts once the lower-right neighbor of the first pixel arrives
   assign emit = (src_row_ff >= ROW_W'(2)) ||
                 (src_row_ff == ROW_W'(1) && src_col_ff != '0);

   always_comb begin
      meta.top_edge     = (dst_row_ff == '0);
      meta.bottom_edge  = (HCMP_W'(dst_row_ff) + HCMP_W'(1)) >= h_eff;
      meta.left_edge    = (dst_col_ff == '0);
      meta.right_edge   = (WCMP_W'(dst_col_ff) + WCMP_W'(1)) >= w_eff;
      meta.end_of_frame = meta.right_edge && meta.bottom_edge;
   end

   assign col_wrap = (WCMP_W'(src_col_ff) + WCMP_W'(1)) >= w_eff;

   always_comb begin
      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      dst_col_in = dst_col_ff;
      dst_row_in = dst_row_ff;
      if (active) begin
         if (col_wrap) begin
            src_col_in = '0;
            src_row_in = src_row_ff + 1'b1;
         end else begin
            src_col_in = src_col_ff + 1'b1;
         end
         if (emit) begin
            if (meta.end_of_frame) begin
               // last output of the frame: the next request opens a new frame
               src_col_in = '0;
               src_row_in = '0;
               dst_col_in = '0;
               dst_row_in = '0;
            end else if (meta.right_edge) begin
               dst_col_in = '0;
               dst_row_in = dst_row_ff + 1'b1;
            end else begin
               dst_col_in = dst_col_ff + 1'b1;
            end
         end
      end
      if (csr_restart) begin
         src_col_in = '0;
         src_row_in = '0;
         dst_col_in = '0;
         dst_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         dst_col_ff <= '0;
         dst_row_ff <= '0;
      end else begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         dst_col_ff <= dst_col_in;
         dst_row_ff <= dst_row_in;
      end
   end

   // ---------------------------------------------------------------------------
   // line store and window, then the kernel, then the result queue
   // ---------------------------------------------------------------------------
   logic                  s1_emit;
   logic                  win_valid;
   meta_type              win_meta;
   window_type            window;
   logic                  res_valid;
   rsp_type               res_data;
   logic                  rsp_pop;
   logic                  fifo_valid;
   rsp_type               fifo_data;
   logic [FIFO_CNT_W-1:0] fifo_count;

   cvf_line_win #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_win (
      .clock      (clock),
      .reset      (reset),
      .push_valid (active),
      .push_emit  (emit),
      .push_pix   (push_pix),
      .push_col   (src_col_ff),
      .push_meta  (meta),
      .s1_emit    (s1_emit),
      .win_valid  (win_valid),
      .win_meta   (win_meta),
      .window     (window)
   );

   cvf_filter u_filter (
      .clock         (clock),
      .reset         (reset),
      .win_valid     (win_valid),
      .win_meta      (win_meta),
      .window        (window),
      .kernel_select (kernel_ff),
      .border_mode   (border_ff),
      .res_valid     (res_valid),
      .res_data      (res_data)
   );

   assign rsp_pop = rsp_ch.valid && rsp_ch.ready;

   cvf_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .pop       (rsp_pop),
      .out_valid (fifo_valid),
      .out_data  (fifo_data),
      .count     (fifo_count)
   );

   assign rsp_ch.valid        = fifo_valid;
   assign rsp_ch.pixel_out    = fifo_data.pixel_out;
   assign rsp_ch.end_of_line  = fifo_data.end_of_line;
   assign rsp_ch.end_of_frame = fifo_data.end_of_frame;

   // queue slots already spoken for: stored results plus outputs still in the pipe
   logic [RES_W-1:0] reserved;

   assign reserved  = RES_W'(fifo_count) + RES_W'(s1_emit) + RES_W'(win_valid) +
                      RES_W'(res_valid);
   assign credit_ok = reserved < RES_W'(FIFO_DEPTH);

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   `CVF_ASSERT_ALWAYS(a_queue_credit, clock, reset, reserved <= RES_W'(FIFO_DEPTH), "result queue overbooked")
   `CVF_ASSERT_ALWAYS(a_row_bound, clock, reset, (HCMP_W + 1)'(src_row_ff) <= (HCMP_W + 1)'(h_eff) + 1'b1, "input row past drain end")
   `CVF_ASSERT_NEXT(a_frame_restart, clock, reset, active && emit && meta.end_of_frame, src_col_ff == '0 && src_row_ff == '0 && dst_row_ff == '0, "frame did not restart")

endmodule

### tb/conv3x3_image_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_image_filter_tb
// streams pixel frames through the 3x3 filter under random gaps and stalls;
// a built-in convolution predictor supplies the expected pixels and markers
// ----------------------------------------------------------------------------
module conv3x3_image_filter_tb;
   import cvf_pkg::*;

   localparam int MAX_W         = DEF_MAX_WIDTH;
   localparam int MAX_H         = DEF_MAX_HEIGHT;
   localparam int SETTLE_CYCLES = 16;       // well past the filter pipe
   localparam int CYCLE_LIMIT   = 100000;
   localparam int RANDOM_ITEMS  = 220;
   localparam int CUT_ITEMS     = 32;       // partial frames at clamped geometry
   localparam int HOLD_CYCLES   = 300;      // long enough to back up the queue

   // kernel arithmetic
   localparam int MEAN_DIV     = 9;
   localparam int GAUSS_DIV    = 16;
   localparam int SOBEL_DIV    = 8;
   localparam int SOBEL_OFFSET = 4 * 255;

   // weights in raster order over the window, one row per kernel code
   localparam int TAP_WEIGHTS [KERNEL_COUNT][9] = '{
      '{ 0, 0, 0,  0, 1, 0,  0, 0, 0},
      '{ 1, 1, 1,  1, 1, 1,  1, 1, 1},
      '{ 1, 2, 1,  2, 4, 2,  1, 2, 1},
      '{-1, 0, 1, -2, 0, 2, -1, 0, 1},
      '{ 1, 2, 1,  0, 0, 0, -1, -2, -1}
   };

   typedef enum int {
      PIX_RANDOM,
      PIX_WHITE,
      PIX_BLACK,
      PIX_CHECKER,
      PIX_EXTREME
   } pixel_pattern_type;

   logic clock = 1'b0;
   logic reset;

   cvf_req_if req_ch ();
   cvf_rsp_if rsp_ch ();
   cvf_csr_if csr_ch ();

   conv3x3_image_filter uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor state: registers, line stores, window and raster counters
   // ------------------------------------------------------------------------
   logic [KERNEL_W-1:0]  kernel_sel = KERNEL_IDENTITY;
   logic [CFG_DIM_W-1:0] width_reg  = RESET_WIDTH;
   logic [CFG_DIM_W-1:0] height_reg = RESET_HEIGHT;
   border_type           border_sel = BORDER_REPLICATE;

   logic [PIXEL_W-1:0] older_line [MAX_W];   // row two above the newest
   logic [PIXEL_W-1:0] newer_line [MAX_W];   // row just above the newest
   logic [PIXEL_W-1:0] window_px  [9];       // raster order, column 2 newest
   int unsigned col_in  = 0;
   int unsigned row_in  = 0;
   int unsigned col_out = 0;
   int unsigned row_out = 0;

   rsp_type predicted_pixels [$];

   int consumed_count = 0;   // requests that moved the raster
   int checked_count  = 0;
   int frame_count    = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   int rx_hold_left   = 0;

   function automatic int unsigned clamp_dim(input logic [CFG_DIM_W-1:0] v,
                                             input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic void restart_raster();
      col_in  = 0;
      row_in  = 0;
      col_out = 0;
      row_out = 0;
   endfunction

   function automatic void apply_register(input csr_index_type idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_KERNEL: kernel_sel = data[KERNEL_W-1:0];
         CSR_WIDTH: begin
            width_reg = data;
            restart_raster();
         end
         CSR_HEIGHT: begin
            height_reg = data;
            restart_raster();
         end
         CSR_BORDER: border_sel = border_type'(data[0]);
         default: ;
      endcase
   endfunction

   function automatic void shift_window(input logic [PIXEL_W-1:0] v, input int unsigned w);
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] mid;
      top = '0;
      mid = '0;
      if (col_in < w) begin
         top = older_line[col_in];
         mid = newer_line[col_in];
         older_line[col_in] = mid;
         newer_line[col_in] = v;
      end
      for (int i = 0; i < 3; i++) begin
         window_px[i*3]     = window_px[i*3 + 1];
         window_px[i*3 + 1] = window_px[i*3 + 2];
      end
      window_px[2] = top;
      window_px[5] = mid;
      window_px[8] = v;
   endfunction

   function automatic logic [PIXEL_W-1:0] filter_pixel(input int unsigned r, c, w, h);
      int  sum;
      int  k;
      int  sy;
      int  sx;
      int  px;
      logic off_y;
      logic off_x;
      sum = 0;
      // codes past the last kernel fall back to identity
      k = (kernel_sel > KERNEL_SOBEL_V) ? int'(KERNEL_IDENTITY) : int'(kernel_sel);
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            off_y = (dy < 0 && r == 0) || (dy > 0 && r + 1 >= h);
            off_x = (dx < 0 && c == 0) || (dx > 0 && c + 1 >= w);
            sy = off_y ? 0 : dy;
            sx = off_x ? 0 : dx;
            px = ((off_y || off_x) && border_sel == BORDER_ZERO) ? 0
                 : int'(window_px[(sy + 1)*3 + sx + 1]);
            sum += TAP_WEIGHTS[k][(dy + 1)*3 + dx + 1] * px;
         end
      end
      case (k)
         KERNEL_MEAN:                   sum = sum / MEAN_DIV;
         KERNEL_GAUSS:                  sum = sum / GAUSS_DIV;
         KERNEL_SOBEL_H, KERNEL_SOBEL_V: sum = (sum + SOBEL_OFFSET) / SOBEL_DIV;
         default: ;
      endcase
      return sum[PIXEL_W-1:0];
   endfunction

   // advance the raster by one accepted request, queue the pixel it releases
   function automatic void convolve_request(input logic [PIXEL_W-1:0] pix,
                                            input logic flush_bit);
      int unsigned w;
      int unsigned h;
      logic draining;
      logic emit;
      logic eol;
      logic eof;
      rsp_type r;
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_H);
      draining = (row_in >= h);
      // a flush inside the frame is dropped without effect
      if (!draining && flush_bit) return;
      emit = (row_in >= 2) || (row_in == 1 && col_in >= 1);
      // once all pixels are in, every request is a drain and carries zero
      shift_window(draining ? '0 : pix, w);
      consumed_count++;
      col_in++;
      if (col_in >= w) begin
         col_in = 0;
         row_in++;
      end
      if (!emit) return;
      eol = (col_out + 1 >= w);
      eof = eol && (row_out + 1 >= h);
      r.pixel_out    = filter_pixel(row_out, col_out, w, h);
      r.end_of_line  = eol;
      r.end_of_frame = eof;
      predicted_pixels.push_back(r);
      if (eof) begin
         restart_raster();
      end else if (eol) begin
         col_out = 0;
         row_out++;
      end else begin
         col_out++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // result side: receiver stall pattern and checker
   // ------------------------------------------------------------------------
   logic [15:0] ready_pattern = 16'hFFFF;
   int          pattern_age   = 0;

   always @(negedge clock) begin
      if (rx_hold_left > 0) begin
         // long hold-off so the block backs up into its input
         rsp_ch.ready <= 1'b0;
         rx_hold_left--;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 2))
               0: ready_pattern = 16'hFFFF;                  // no stalls
               1: ready_pattern = 16'($urandom) | 16'($urandom);
               default: ready_pattern = 16'($urandom) | 16'h0001;
            endcase
            pattern_age = $urandom_range(16, 96);
         end
         pattern_age--;
         rsp_ch.ready  <= ready_pattern[0];
         ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (predicted_pixels.size() == 0) begin
            $error("unexpected filtered pixel %0d with no request pending",
                   rsp_ch.pixel_out);
            error_count++;
         end else begin
            want = predicted_pixels.pop_front();
            check_field("pixel_out", want.pixel_out, rsp_ch.pixel_out);
            check_field("end_of_line", want.end_of_line, rsp_ch.end_of_line);
            check_field("end_of_frame", want.end_of_frame, rsp_ch.end_of_frame);
            checked_count++;
            if (want.end_of_frame) frame_count++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // one request, sent in bursts with random gaps in between
   task automatic send_request(input logic [PIXEL_W-1:0] pix, input logic flush_bit);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid    <= 1'b1;
      req_ch.pixel_in <= pix;
      req_ch.flush    <= flush_bit;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      convolve_request(pix, flush_bit);
   endtask

   // stop sending, let every pending pixel come out and the pipe empty
   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (predicted_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      wait_for_drain();
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      apply_register(idx, data);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [PIXEL_W-1:0] frame_pixel(input pixel_pattern_type mode,
                                                      input int n, input int w);
      case (mode)
         PIX_WHITE:   return 8'hFF;
         PIX_BLACK:   return 8'h00;
         PIX_CHECKER: return (((n % w) + (n / w)) % 2 != 0) ? 8'hFF : 8'h00;
         PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         default:     return 8'($urandom);
      endcase
   endfunction

   // one full frame plus its drain; noise adds stray flushes and drain pixels
   task automatic run_frame(input int noise_pct, input pixel_pattern_type mode,
                            input int pause_at);
      int w;
      int h;
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_H);
      for (int n = 0; n < w * h; n++) begin
         if (n == pause_at) wait_for_drain();
         if ($urandom_range(0, 99) < noise_pct) send_request(8'($urandom), 1'b1);
         send_request(frame_pixel(mode, n, w), 1'b0);
      end
      for (int n = 0; n <= w; n++)
         send_request(8'($urandom), ($urandom_range(0, 99) < noise_pct) ? 1'b0 : 1'b1);
      // a flush right after the frame end lands in the next frame and is dropped
      if ($urandom_range(0, 99) < noise_pct) send_request(8'($urandom), 1'b1);
   endtask

   task automatic set_geometry(input int w, input int h);
      write_csr(CSR_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_HEIGHT, CSR_DATA_W'(h));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // small frames hitting every kernel, stray flushes and drain pixels
   task automatic test_directed_cases();
      write_csr(CSR_BORDER, BORDER_REPLICATE);
      write_csr(CSR_KERNEL, KERNEL_SOBEL_V);
      set_geometry(2, 2);
      send_request(8'hFF, 1'b0);
      send_request(8'h5A, 1'b1);        // flush mid-frame, dropped
      send_request(8'h00, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'hA5, 1'b1);
      send_request(8'hFF, 1'b0);        // pixel during drain, read as zero
      send_request(8'h00, 1'b1);
      send_request(8'h3C, 1'b1);        // flush after frame end, dropped

      // unknown kernel code with junk above the field
      write_csr(CSR_KERNEL, {8'hFF, 3'd7});
      write_csr(CSR_BORDER, BORDER_ZERO);
      set_geometry(1, 1);
      run_frame(0, PIX_RANDOM, -1);

      write_csr(CSR_KERNEL, KERNEL_MEAN);
      set_geometry(2, 1);
      run_frame(0, PIX_WHITE, -1);

      write_csr(CSR_KERNEL, KERNEL_GAUSS);
      set_geometry(1, 2);
      run_frame(0, PIX_WHITE, -1);

      write_csr(CSR_KERNEL, KERNEL_SOBEL_H);
      set_geometry(2, 2);
      run_frame(0, PIX_CHECKER, -1);
   endtask

   // geometry writes in mid-frame throw the partial frame away
   task automatic test_geometry_restart();
      write_csr(CSR_KERNEL, KERNEL_IDENTITY);
      write_csr(CSR_BORDER, BORDER_REPLICATE);
      set_geometry(4, 3);
      repeat (5) send_request(8'($urandom), 1'b0);
      write_csr(CSR_WIDTH, 11'd3);
      run_frame(0, PIX_RANDOM, -1);
      // this partial frame already released its first pixel
      repeat (5) send_request(8'($urandom), 1'b0);
      write_csr(CSR_HEIGHT, 11'd4);
      run_frame(0, PIX_RANDOM, -1);
   endtask

   // values that clamp; oversize frames are cut short and restarted
   task automatic test_geometry_extremes();
      // zero width and height both read as one
      write_csr(CSR_KERNEL, 11'($urandom_range(0, 7)));
      set_geometry(0, 0);
      run_frame(2, PIX_RANDOM, -1);
      // oversize width clamps to the widest row
      write_csr(CSR_KERNEL, KERNEL_SOBEL_H);
      write_csr(CSR_BORDER, BORDER_ZERO);
      set_geometry(11'h7FF, 0);
      repeat (CUT_ITEMS) send_request(8'($urandom), 1'b0);
      // oversize height clamps; once two rows are in, a one-pixel column releases a pixel per request
      write_csr(CSR_KERNEL, KERNEL_SOBEL_V);
      set_geometry(1, 11'h7FF);
      repeat (CUT_ITEMS) send_request(frame_pixel(PIX_EXTREME, 0, 1), 1'b0);
      write_csr(CSR_KERNEL, KERNEL_GAUSS);
      write_csr(CSR_BORDER, BORDER_REPLICATE);
      set_geometry(3, 0);
      run_frame(2, PIX_CHECKER, -1);
   endtask

   // receiver holds off while requests keep coming, then the sender waits out
   task automatic test_backpressure();
      write_csr(CSR_KERNEL, KERNEL_GAUSS);
      write_csr(CSR_BORDER, BORDER_ZERO);
      set_geometry(8, 6);
      rx_hold_left = HOLD_CYCLES;
      run_frame(0, PIX_RANDOM, 20);
   endtask

   // random registers and frames, mostly well formed
   task automatic test_random_frames();
      int target;
      int k;
      int w;
      int h;
      int cut;
      target = consumed_count + RANDOM_ITEMS;
      while (consumed_count < target) begin
         k = $urandom_range(0, 7);
         write_csr(CSR_KERNEL, ($urandom_range(0, 3) == 0)
                   ? {8'($urandom), 3'(k)} : CSR_DATA_W'(k));
         write_csr(CSR_BORDER, {10'($urandom), 1'($urandom)});
         if ($urandom_range(0, 1) == 0) begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            set_geometry(w, h);
         end
         if ($urandom_range(0, 9) == 0) begin
            // broken frame: cut short and restarted by a width write
            cut = $urandom_range(1, clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H));
            repeat (cut) send_request(8'($urandom), 1'b0);
            write_csr(CSR_WIDTH, width_reg);
         end
         run_frame(5, pixel_pattern_type'($urandom_range(0, 4)), -1);
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      req_ch.valid    = 1'b0;
      req_ch.pixel_in = '0;
      req_ch.flush    = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = CSR_KERNEL;
      csr_ch.data     = '0;
      rsp_ch.ready    = 1'b0;
      foreach (older_line[i]) begin
         older_line[i] = '0;
         newer_line[i] = '0;
      end
      foreach (window_px[i]) window_px[i] = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_geometry_restart();
      test_backpressure();
      test_geometry_extremes();
      test_random_frames();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d pixel requests, %0d filtered pixels checked in %0d frames",
               consumed_count, checked_count, frame_count);
      $display("all kernel codes, both border modes, clamped geometry and restarts");
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
